// ===== rtl/crx_pkg.sv =====
// Shared types and constants for the clocked serial frame receiver.
`default_nettype none

package crx_pkg;

	// Frame format
	localparam int DATA_BITS = 8;
	localparam int BIT_CNT_W = 4;

	// Phase codes reported as status
	localparam logic [2:0] PH_WAIT = 3'd0;
	localparam logic [2:0] PH_DATA = 3'd1;
	localparam logic [2:0] PH_STOP = 3'd2;
	localparam logic [2:0] PH_DONE = 3'd3;
	localparam logic [2:0] PH_ERR  = 3'd4;

	// Input word codes
	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_EDGE    = 1'b1;

	typedef struct packed {
		logic op;
		logic line_level;
	} crx_item_t;

	typedef struct packed {
		logic                 byte_valid;
		logic [DATA_BITS-1:0] byte_value;
		logic [2:0]           status;
	} crx_result_t;

endpackage

`default_nettype wire

// ===== rtl/clocked_serial_frame_receiver.sv =====
// Top level of the clocked serial frame receiver: input register, framing, result register.
//
//   channel   dir  payload
//   s_*       in   tuser = op, tdata[0] = line_level
//   m_*       out  tuser = byte_valid, tdata[7:0] = byte_value, tdata[10:8] = status
//   cfg_*     in   byte_count, written when cfg_we is high
//
// One word per cycle while m_tready does not stall; an accepted word is held in the input
// register and then in the result register, from which it is offered on m_tvalid.
// arst_n clears both stages and puts the receiver in the done phase, byte count 1.
// A stall on m_tready holds the result register and then the input register;
// s_tready drops only when both are full.
`default_nettype none

module clocked_serial_frame_receiver
	import crx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
	input  wire logic        s_tuser,   // [0] op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] byte_value, [10:8] status, [15:11] zero
	output logic             m_tuser,   // [0] byte_valid
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	logic        valid_s1;
	crx_item_t   item_s1;
	logic        out_free;
	logic        fire;
	crx_result_t step_res;
	crx_result_t out_res;

	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op         <= s_tuser;
			item_s1.line_level <= s_tdata[0];
		end
	end

	crx_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.result    (step_res)
	);

	crx_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result_in (step_res),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_q  (out_res)
	);

	// Pack the result word
	assign m_tdata = {5'd0, out_res.status, out_res.byte_value};
	assign m_tuser = out_res.byte_valid;

endmodule

`default_nettype wire

// ===== rtl/crx_step.sv =====
// Receiver state registers and the per-word framing logic.
`default_nettype none

module crx_step
	import crx_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic                 fire,
	input  wire crx_item_t            item,
	output crx_result_t               result
);

	logic [7:0]           byte_count_q;
	logic [2:0]           phase_q, phase_d;
	logic [BIT_CNT_W-1:0] bits_q, bits_d;
	logic [DATA_BITS-1:0] shift_q, shift_d;
	logic [7:0]           bytes_q, bytes_d;
	logic                 valid_d;
	logic [DATA_BITS-1:0] value_d;
	logic [BIT_CNT_W-1:0] bits_dec;

	assign bits_dec = bits_q - BIT_CNT_W'(1);

	// Hold the byte count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 8'd1;
		end else if (cfg_we) begin
			byte_count_q <= cfg_wdata;
		end
	end

	// Compute next state and result for one word
	always_comb begin
		phase_d = phase_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		bytes_d = bytes_q;
		valid_d = 1'b0;
		value_d = '0;
		if (item.op == OP_RESTART) begin
			bytes_d = byte_count_q;
			phase_d = PH_WAIT;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (!item.line_level) begin
						phase_d = PH_DATA;
						bits_d  = BIT_CNT_W'(DATA_BITS);
						shift_d = '0;
					end
				end
				PH_DATA: begin
					shift_d = {item.line_level, shift_q[DATA_BITS-1:1]};
					bits_d  = bits_dec;
					if (bits_dec == '0) begin
						valid_d = 1'b1;
						value_d = {item.line_level, shift_q[DATA_BITS-1:1]};
						bytes_d = bytes_q - 8'd1;
						phase_d = PH_STOP;
					end
				end
				PH_STOP: begin
					if (item.line_level) begin
						phase_d = (bytes_q == 8'd0) ? PH_DONE : PH_WAIT;
					end else begin
						phase_d = PH_ERR;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result.byte_valid = valid_d;
	assign result.byte_value = value_d;
	assign result.status     = phase_d;

	// Advance state on each processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			bits_q  <= '0;
			shift_q <= '0;
			bytes_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			bytes_q <= bytes_d;
		end
	end

`ifndef SYNTHESIS
	a_data_bits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> (bits_q != '0 && bits_q <= BIT_CNT_W'(DATA_BITS)))
		else $error("bit counter out of range in data phase");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_RESTART |=> phase_q == PH_WAIT)
		else $error("restart did not return to wait phase");

	a_byte_stop: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.byte_valid |=> phase_q == PH_STOP && bits_q == '0)
		else $error("completed byte not followed by stop phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/crx_out_reg.sv =====
// Result register between the framing logic and the output stream.
`default_nettype none

module crx_out_reg
	import crx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire crx_result_t result_in,
	output logic             free,
	output logic             out_valid,
	input  wire logic        out_ready,
	output crx_result_t      result_q
);

	logic valid_q;

	// Free when empty or when the held word leaves this cycle
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Capture the payload on load
	always_ff @(posedge clk) begin
		if (free && load) begin
			result_q <= result_in;
		end
	end

endmodule

`default_nettype wire
